FILE: hw/rtl/plst_pkg.sv
// ----------------------------------------------------------------------------
// plst_pkg
// Shared widths, result codes and controller/datapath interface structs for
// the positional list insert block.
// ----------------------------------------------------------------------------
`default_nettype none

package plst_pkg;

    localparam int PLST_CAPACITY = 32;
    localparam int POS_W         = 6;
    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int IN_TDATA_W    = 40;   // position + value, padded to bytes
    localparam int OUT_TUSER_W   = 3;    // status + direction

    typedef enum logic [STATUS_W-1:0] {
        ST_ELEMENT = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } plst_status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic         capture;    // latch request, load index with count
        logic         rej;        // queue a reject result
        plst_status_t rej_code;
        logic         shift_rd;   // read entry idx-1, write it to idx next cycle
        logic         insert;     // write value at position, bump count
        logic         emit;       // read entry idx as a list result
        logic         emit_dir;
        logic         emit_last;
        logic         idx_inc;
        logic         idx_dec;
    } plst_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pos_bad;     // incoming position above count
        logic full;        // list holds CAPACITY entries
        logic pend_free;   // result staging slot is empty
        logic can_issue;   // staging slot empty or drains this cycle
        logic idx_gt_pos;  // shift still has entries to move
        logic idx_is_top;  // index at last entry
        logic idx_zero;    // index at first entry
    } plst_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/positional_list_insert.sv
// ----------------------------------------------------------------------------
// positional_list_insert
// Bounded ordered list of signed 32-bit values with insert at a position;
// every accepted insert streams the list forward and then backward.
// ----------------------------------------------------------------------------
//
//  channel | dir | signals                      | contents
//  --------+-----+------------------------------+-------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata    | position [5:0], value [37:6]
//  m_      | out | m_tvalid m_tready m_tdata    | element [31:0]
//          |     | m_tuser m_tlast              | status [1:0], direction [2]
//
//  Sequence: a rejected request is answered through the staging slot, and the
//  next request is taken once that slot has drained. An insert of n-1 -> n
//  entries at position p is accepted, moves entries p..n-2 up one slot through
//  the entry memory, writes the new value, then issues n forward and n backward
//  results, one per cycle while m_tready does not stall, before the slot drains.
//  Reset clears the count and all handshake state; entry memory is not
//  cleared. A stalled m_tready holds the output register; one more result
//  waits in the staging slot, then the sequencer halts. A new request is
//  taken once the staging slot is empty, while the final result may still
//  sit in the output register.
//
`default_nettype none

module positional_list_insert
    import plst_pkg::*;
#(
    parameter int CAPACITY = PLST_CAPACITY
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,    // position[5:0], value[37:6], zero pad
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [DATA_W-1:0]           m_tdata,    // element[31:0]
    output logic [OUT_TUSER_W-1:0]      m_tuser,    // status[1:0], direction[2]
    output logic                        m_tlast
);

    plst_cmd_t cmd;
    plst_sts_t sts;

    // Sequencer: decides which datapath step runs each cycle
    plst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: entry memory, count, staging slot and output register
    plst_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Never start a shift into a full list or past the count
    a_no_capture_bad: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!sts.full && !sts.pos_bad))
        else $error("insert started on a full list or bad position");

    // Never overwrite a result still held in the staging slot
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.can_issue)
        else $error("list result issued over a held result");

    // A reject only answers an accepted request
    a_rej_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rej |-> (s_tvalid && s_tready))
        else $error("reject raised without an accepted request");

    // Requests are taken only with an empty staging slot
    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> sts.pend_free)
        else $error("request taken while a result is staged");

endmodule

`default_nettype wire

FILE: hw/rtl/plst_ctrl.sv
// ----------------------------------------------------------------------------
// plst_ctrl
// Sequencer for one insert request: check, shift, insert, forward pass,
// backward pass.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_ctrl
    import plst_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire plst_sts_t sts,
    output plst_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SHIFT  = 5'b00010,
        S_INSERT = 5'b00100,
        S_FWD    = 5'b01000,
        S_BWD    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE) && sts.pend_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rej_code = ST_ELEMENT;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    if (sts.pos_bad)
                    begin
                        cmd.rej      = 1'b1;
                        cmd.rej_code = ST_INVALID;
                    end
                    else if (sts.full)
                    begin
                        cmd.rej      = 1'b1;
                        cmd.rej_code = ST_FULL;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                // the pending write of the last moved entry drains on the exit cycle
                if (sts.idx_gt_pos)
                begin
                    cmd.shift_rd = 1'b1;
                    cmd.idx_dec  = 1'b1;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_FWD;
            end
            S_FWD:
            begin
                if (sts.can_issue)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_dir = 1'b0;
                    if (sts.idx_is_top)
                        state_next = S_BWD;
                    else
                        cmd.idx_inc = 1'b1;
                end
            end
            S_BWD:
            begin
                if (sts.can_issue)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_dir  = 1'b1;
                    cmd.emit_last = sts.idx_zero;
                    if (sts.idx_zero)
                        state_next = S_IDLE;
                    else
                        cmd.idx_dec = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/plst_dpath.sv
// ----------------------------------------------------------------------------
// plst_dpath
// Entry memory, count, index counter, result staging slot and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_dpath
    import plst_pkg::*;
#(
    parameter int CAPACITY = PLST_CAPACITY
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire plst_cmd_t              cmd,
    output plst_sts_t                   sts,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [DATA_W-1:0]           m_tdata,
    output logic [OUT_TUSER_W-1:0]      m_tuser,
    output logic                        m_tlast
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [CW-1:0]     count_reg,    count_next;
    logic [AW-1:0]     idx_reg,      idx_next;
    logic              wr_pend_reg;
    logic              pend_vld_reg, pend_vld_next;
    logic              out_vld_reg,  out_vld_next;

    logic [AW-1:0]     pos_reg;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] rd_data_reg;
    plst_status_t      pend_code_reg;
    logic              pend_dir_reg;
    logic              pend_last_reg;
    logic              pend_zero_reg;
    logic [DATA_W-1:0] out_elem_reg;
    plst_status_t      out_code_reg;
    logic              out_dir_reg;
    logic              out_last_reg;

    logic [POS_W-1:0]  in_pos;
    logic [DATA_W-1:0] in_val;
    logic              out_take;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    assign in_pos = s_tdata[POS_W-1:0];
    assign in_val = s_tdata[POS_W +: DATA_W];

    assign out_take = pend_vld_reg && (!out_vld_reg || m_tready);
    assign rd_en    = cmd.shift_rd || cmd.emit;
    assign rd_addr  = cmd.shift_rd ? (idx_reg - AW'(1)) : idx_reg;

    always_comb
    begin
        sts.pos_bad    = ({1'b0, in_pos} > (POS_W + 1)'(count_reg));
        sts.full       = (count_reg == CW'(CAPACITY));
        sts.pend_free  = !pend_vld_reg;
        sts.can_issue  = !pend_vld_reg || out_take;
        sts.idx_gt_pos = (idx_reg > pos_reg);
        sts.idx_is_top = ((CW'(idx_reg) + CW'(1)) == count_reg);
        sts.idx_zero   = (idx_reg == '0);
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
            count_next = count_reg + CW'(1);

        idx_next = idx_reg;
        if (cmd.capture)
            idx_next = count_reg[AW-1:0];
        else if (cmd.insert)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + AW'(1);
        else if (cmd.idx_dec)
            idx_next = idx_reg - AW'(1);

        pend_vld_next = pend_vld_reg;
        if (cmd.emit || cmd.rej)
            pend_vld_next = 1'b1;
        else if (out_take)
            pend_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (out_take)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            idx_reg      <= '0;
            wr_pend_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            wr_pend_reg  <= cmd.shift_rd;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Entry memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
            mem[pos_reg] <= val_reg;
        else if (wr_pend_reg)
            mem[idx_reg + AW'(1)] <= rd_data_reg;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pos_reg <= in_pos[AW-1:0];
            val_reg <= in_val;
        end
        if (cmd.emit)
        begin
            pend_code_reg <= ST_ELEMENT;
            pend_dir_reg  <= cmd.emit_dir;
            pend_last_reg <= cmd.emit_last;
            pend_zero_reg <= 1'b0;
        end
        else if (cmd.rej)
        begin
            pend_code_reg <= cmd.rej_code;
            pend_dir_reg  <= 1'b0;
            pend_last_reg <= 1'b1;
            pend_zero_reg <= 1'b1;
        end
        if (out_take)
        begin
            out_elem_reg <= pend_zero_reg ? '0 : rd_data_reg;
            out_code_reg <= pend_code_reg;
            out_dir_reg  <= pend_dir_reg;
            out_last_reg <= pend_last_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_elem_reg;
    assign m_tuser  = {out_dir_reg, out_code_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: tb/sv/positional_list_insert_checker.sv
// ----------------------------------------------------------------------------
// positional_list_insert_checker
// Watches both stream channels of the positional list insert block, keeps its
// own copy of the list, predicts every result of each accepted request and
// compares the results in order as they leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module positional_list_insert_checker
    import plst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // position[5:0], value[37:6], zero pad
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [DATA_W-1:0]      m_tdata,    // element[31:0]
    input  logic [OUT_TUSER_W-1:0] m_tuser,    // status[1:0], direction[2]
    input  logic                   m_tlast,
    output int                     mismatches,
    output int                     outstanding
);

    typedef struct {
        plst_status_t             status;
        logic                     direction;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } list_result_t;

    list_result_t             pending_results[$];
    logic signed [DATA_W-1:0] list_mem [PLST_CAPACITY];
    int unsigned              list_len = 0;
    int                       mismatch_count = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = pending_results.size();

    function automatic void queue_result(input plst_status_t status, input logic direction,
                                         input logic signed [DATA_W-1:0] element,
                                         input logic last);
        list_result_t r;
        r.status    = status;
        r.direction = direction;
        r.element   = element;
        r.last      = last;
        pending_results.push_back(r);
    endfunction

    // Apply one insert request to the list copy and queue what it must produce.
    function automatic void insert_and_walk(input logic [POS_W-1:0] pos,
                                            input logic signed [DATA_W-1:0] val);
        if (pos > list_len) begin
            queue_result(ST_INVALID, 1'b0, '0, 1'b1);
        end else if (list_len >= PLST_CAPACITY) begin
            queue_result(ST_FULL, 1'b0, '0, 1'b1);
        end else begin
            for (int i = list_len; i > pos; i--)
                list_mem[i] = list_mem[i-1];
            list_mem[pos] = val;
            list_len++;
            for (int i = 0; i < list_len; i++)
                queue_result(ST_ELEMENT, 1'b0, list_mem[i], 1'b0);
            for (int i = list_len - 1; i >= 0; i--)
                queue_result(ST_ELEMENT, 1'b1, list_mem[i], i == 0);
        end
    endfunction

    // Results leave strictly after their request, so retire them before
    // predicting the request taken at the same edge.
    always @(posedge clk) begin
        list_result_t exp_r;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected result: status=%0d dir=%0b elem=%0d last=%0b",
                                 $time, m_tuser[1:0], m_tuser[2], $signed(m_tdata), m_tlast);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (m_tuser[1:0] !== exp_r.status || m_tuser[2] !== exp_r.direction ||
                        m_tdata !== exp_r.element || m_tlast !== exp_r.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("[%0t] mismatch: expected status=%0d dir=%0b elem=%0d last=%0b, got status=%0d dir=%0b elem=%0d last=%0b",
                                     $time, exp_r.status, exp_r.direction, exp_r.element,
                                     exp_r.last, m_tuser[1:0], m_tuser[2], $signed(m_tdata),
                                     m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                insert_and_walk(s_tdata[POS_W-1:0], s_tdata[POS_W+DATA_W-1:POS_W]);
        end
    end

endmodule

FILE: tb/sv/positional_list_insert_tb.sv
// ----------------------------------------------------------------------------
// positional_list_insert_tb
// Drives insert requests into the positional list insert block: a directed
// opening with edge positions and values, then random requests that grow the
// list to capacity and keep hitting the reject paths. Random idling on both
// channels, one long output hold-off and one full drain. The checker next to
// the block does all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module positional_list_insert_tb;
    import plst_pkg::*;

    localparam int NUM_REQUESTS   = 230;
    localparam int HOLD_CYCLES    = 400;   // output hold-off, long enough to back up the input
    localparam int DRAIN_REQUEST  = 100;   // request number before which the sender drains
    localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles allowed before giving up
    localparam int TAIL_CYCLES    = 200;   // idle tail after the last result

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // position[5:0], value[37:6], zero pad
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [DATA_W-1:0]      m_tdata;         // element[31:0]
    logic [OUT_TUSER_W-1:0] m_tuser;         // status[1:0], direction[2]
    logic                   m_tlast;

    int  mismatches;
    int  outstanding;

    // Stimulus-side bookkeeping: how long the list is, so positions can be
    // aimed at valid and invalid slots, and what kinds of request went in.
    int  sent       = 0;
    int  list_tally = 0;
    int  n_inserts  = 0;
    int  n_invalid  = 0;
    int  n_full     = 0;
    wire steady     = (sent >= 120) && (sent < 170);   // no idling on either side here

    positional_list_insert dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    positional_list_insert_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one request and hold it until the block takes it. Called just
    // after a rising edge; returns at the edge where the request was taken,
    // so each step sees at most one update of s_tvalid.
    task automatic send_request(input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] val);
        while (!steady && $urandom_range(99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-POS_W-DATA_W){1'b0}}, val, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
        // Track the list length the same way the block must: invalid beats full.
        if (pos > list_tally)
            n_invalid++;
        else if (list_tally >= PLST_CAPACITY)
            n_full++;
        else
        begin
            list_tally++;
            n_inserts++;
        end
    endtask

    // Sender: directed opening, then random requests.
    initial
    begin
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: rejects on an empty list, then front, end and middle inserts
        // with extreme values, mixed with positions just and far past the count.
        send_request(6'd63, 32'sd5);
        send_request(6'd1,  32'sd7);
        send_request(6'd0,  32'sh8000_0000);
        send_request(6'd1,  32'sh7fff_ffff);
        send_request(6'd1,  32'sd0);
        send_request(6'd0,  -32'sd1);
        send_request(6'd2,  32'sh5a5a_5a5a);
        send_request(6'd5,  32'sd1);
        send_request(6'd7,  32'sh1234_5678);
        send_request(6'd32, 32'sh0f0f_0f0f);
        send_request(6'd0,  32'sh8000_0001);
        send_request(6'd42, 32'sh7fff_fffe);
        send_request(6'd21, 32'sha5a5_a5a5);
        send_request(6'd6,  32'sh0000_ffff);

        while (sent < NUM_REQUESTS)
        begin
            // Drain once: drop valid and wait for every predicted result.
            // Step one edge first so the last request has been predicted.
            if (sent == DRAIN_REQUEST)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                wait (outstanding == 0);
                @(posedge clk);
            end

            // Mostly valid positions while the list grows, aimed at front,
            // end and random middle slots; the rest land past the count.
            if (list_tally < PLST_CAPACITY)
            begin
                if ($urandom_range(99) < 75)
                begin
                    case ($urandom_range(3))
                        0:       pos = '0;
                        1:       pos = POS_W'(list_tally);
                        default: pos = POS_W'($urandom_range(list_tally));
                    endcase
                end
                else
                    pos = POS_W'($urandom_range(63, list_tally + 1));
            end
            else if ($urandom_range(1))
                pos = POS_W'($urandom_range(PLST_CAPACITY));
            else
                pos = POS_W'($urandom_range(63, PLST_CAPACITY + 1));

            case ($urandom_range(9))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7fff_ffff;
                2:       val = '0;
                3:       val = '1;
                default: val = $urandom();
            endcase

            send_request(pos, val);
        end
        s_tvalid <= 1'b0;

        // Wait for the last results, then a tail for anything stray.
        @(posedge clk);
        wait (outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d inserts (list reached %0d of %0d entries),",
                 sent, n_inserts, list_tally, PLST_CAPACITY);
        $display("%0d invalid-position and %0d full-list rejects, with output hold-off and drain.",
                 n_invalid, n_full);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls, one long hold-off early on while the sender
    // keeps offering, and a stall-free stretch.
    initial
    begin
        int hold_left;
        bit hold_done;

        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && sent >= 12)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 29);
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    initial
    begin
        int quiet;

        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet, outstanding);
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule

FILE: positional_list_insert.f
hw/rtl/plst_pkg.sv
hw/rtl/plst_ctrl.sv
hw/rtl/plst_dpath.sv
hw/rtl/positional_list_insert.sv
tb/sv/positional_list_insert_checker.sv
tb/sv/positional_list_insert_tb.sv
